// ===== hw/rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the smallest-three quaternion codec
// Holds the fixed field widths, the sqrt2 scale factor and the side payload
// that travels alongside the square-root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int CODE_W  = 10;            // bits per quantized component
  localparam int SAMP_W  = 16;            // bits per Q1.15 sample
  localparam int LANES   = 3;             // components kept in the packed word
  localparam int RAD_W   = 31;            // radicand width, holds 2^30
  localparam int ROOT_W  = 32;            // working root register width
  localparam int ISQ_STEPS = 16;          // one result bit per stage

  // round(sqrt2 * 2^30)
  localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;

  localparam logic KIND_COMPRESS   = 1'b0;
  localparam logic KIND_DECOMPRESS = 1'b1;

  typedef logic [CODE_W-1:0]        code_t;
  typedef logic signed [SAMP_W-1:0] samp_t;

  // Payload that rides along with the radicand through the root pipeline.
  typedef struct packed {
    logic  kind;
    logic [1:0] idx;
    code_t [LANES-1:0] codes;
    samp_t [LANES-1:0] vals;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_lane.sv =====
// ----------------------------------------------------------------------------
// stq_lane: one component lane
// Scales one kept component by sqrt2 and turns it into a code (compress), or
// turns a code back into a sample and squares it (decompress). Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_lane (
  input  wire logic            clk,
  input  wire logic            en2,     // load product stage
  input  wire logic            en3,     // load code / sample stage
  input  wire logic            en4,     // load square stage
  input  wire logic            kind,
  input  wire logic signed [16:0] raw,  // sign-corrected component
  input  wire stq_pkg::code_t  code_in,
  output stq_pkg::code_t       code_out,
  output stq_pkg::samp_t       val_out,
  output logic [31:0]          sq_out
);
  import stq_pkg::*;

  localparam logic signed [49:0] LIM     = 50'sh2000_0000_0000;
  localparam logic        [49:0] Q_HALF  = 50'h8_0000_0000;
  localparam logic signed [49:0] D_HALF  = 50'sh200_0000;

  logic signed [11:0] d;
  logic signed [11:0] dabs;
  logic signed [17:0] op;
  logic signed [49:0] prod_nxt, prod_r;
  logic               kind2_r, neg2_r;
  logic signed [49:0] tc;
  logic        [49:0] qsum;
  logic        [10:0] code_full;
  code_t              code_nxt, code3_r, code4_r;
  logic signed [49:0] rr;
  logic        [14:0] mag;
  samp_t              val_nxt, val3_r, val4_r;
  logic signed [31:0] sq_nxt;
  logic        [31:0] sq_r;

  // Operand select and the sqrt2 multiply.
  always_comb begin
    d    = $signed({1'b0, code_in, 1'b0}) - 12'sd1024;
    dabs = d[11] ? -d : d;
    op   = kind ? {{6{dabs[11]}}, dabs} : {raw[16], raw};
    prod_nxt = op * SQRT2_Q30;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_r  <= prod_nxt;
      kind2_r <= kind;
      neg2_r  <= d[11];
    end
  end

  // Clamp and round to a code, or round the dequantized magnitude.
  always_comb begin
    tc = prod_r;
    if (tc > LIM) tc = LIM;
    if (tc < -LIM) tc = -LIM;
    qsum = $unsigned(tc + LIM) + Q_HALF;
    code_full = qsum[46:36];
    code_nxt  = code_full[10] ? {CODE_W{1'b1}} : code_full[CODE_W-1:0];
    rr  = prod_r + D_HALF;
    mag = rr[40:26];
    val_nxt = neg2_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (kind2_r == KIND_COMPRESS) begin
      val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      code3_r <= code_nxt;
      val3_r  <= val_nxt;
    end
  end

  // Square of the rebuilt sample.
  assign sq_nxt = val3_r * val3_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      code4_r <= code3_r;
      val4_r  <= val3_r;
      sq_r    <= $unsigned(sq_nxt);
    end
  end

  assign code_out = code4_r;
  assign val_out  = val4_r;
  assign sq_out   = sq_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stq_isqrt.sv =====
// ----------------------------------------------------------------------------
// stq_isqrt: pipelined integer square root
// Digit-by-digit root, one result bit per stage, with the side payload
// carried in step. Leaves the floor root and its remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_isqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [stq_pkg::RAD_W-1:0] x,
  input  wire stq_pkg::side_t           side_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [stq_pkg::ROOT_W-1:0]    root,
  output logic [stq_pkg::RAD_W-1:0]     rem,
  output stq_pkg::side_t                side_out
);
  import stq_pkg::*;

  logic              v_r    [ISQ_STEPS];
  logic              rdy    [ISQ_STEPS+1];
  logic [RAD_W-1:0]  n_r    [ISQ_STEPS];
  logic [ROOT_W-1:0] r_r    [ISQ_STEPS];
  side_t             side_r [ISQ_STEPS];

  assign rdy[ISQ_STEPS] = out_ready;

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic              v_in;
    logic [RAD_W-1:0]  n_in;
    logic [ROOT_W-1:0] r_in;
    side_t             s_in;
    logic [ROOT_W-1:0] trial;
    logic [RAD_W-1:0]  n_nxt;
    logic [ROOT_W-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = x;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
      assign s_in = side_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // One subtract-and-compare step of the root.
    always_comb begin
      trial = r_in + BIT;
      if ({1'b0, n_in} >= trial) begin
        n_nxt = n_in - trial[RAD_W-1:0];
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        n_r[k]    <= n_nxt;
        r_r[k]    <= r_nxt;
        side_r[k] <= s_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[ISQ_STEPS-1];
  assign root      = r_r[ISQ_STEPS-1];
  assign rem       = n_r[ISQ_STEPS-1];
  assign side_out  = side_r[ISQ_STEPS-1];

  // The remainder of a floor root never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, rem} <= (r_r[ISQ_STEPS-1] << 1)))
    else $error("root remainder out of range");

  // Payload and valid stay together: a stalled last stage holds its root.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(root) && $stable(rem))
    else $error("root stage lost its result under stall");

  // The first stage can take a request whenever it is empty.
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("empty root stage refused a request");

endmodule

`default_nettype wire

// ===== hw/rtl/smallest_three_quat_codec.sv =====
// ----------------------------------------------------------------------------
// smallest_three_quat_codec: smallest-three quaternion compress / decompress
// Compresses four Q1.15 components into a 32-bit word or rebuilds them.
// ----------------------------------------------------------------------------
// The block takes one request per clock and gives one result per request, in
// order. A request passes through the stage that finds the largest component,
// the stages of the three component lanes (sqrt2 multiply, rounding, square),
// the stage that forms the radicand, the bit-per-stage square root and the
// output register. Every stage stalls only when the stage after it is full, so
// the rate stays at one request per cycle while the output is taken. Compress
// results carry zero components; decompress results carry a zero packed word.
`default_nettype none

module smallest_three_quat_codec (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // comp_w, comp_x, comp_y, comp_z, packed_in
  input  wire logic [95:0]  in_tdata,
  // kind
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // packed_out, out_w, out_x, out_y, out_z, largest_index, zero fill
  output logic [103:0]      out_tdata
);
  import stq_pkg::*;

  samp_t              comp [4];
  logic signed [16:0] q    [4];
  logic signed [16:0] qabs [4];
  logic [1:0]         idx;
  logic signed [16:0] best;
  logic               kind_in;
  logic [1:0]         idx_in;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic               rdy1, rdy2, rdy3, rdy4, rdy5;
  logic               kind1_r, kind2_r, kind3_r, kind4_r;
  logic [1:0]         idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [16:0] raw1_r  [LANES];
  code_t              code1_r [LANES];
  code_t              lcode   [LANES];
  samp_t              lval    [LANES];
  logic [31:0]        lsq     [LANES];

  logic [31:0]        sum;
  logic [RAD_W-1:0]   rad_nxt, rad5_r;
  side_t              side_nxt, side5_r, side_o;
  logic               isq_rdy, isq_valid;
  logic [ROOT_W-1:0]  isq_root;
  logic [RAD_W-1:0]   isq_rem;

  logic               out_valid_r, out_kind_r, rdy_out;
  logic [103:0]       out_data_r, out_data_nxt;
  logic [ROOT_W-1:0]  rnd;
  samp_t              root_s;
  samp_t              res [4];

  // Find the largest component, first index on ties, and fix its sign.
  always_comb begin
    kind_in = in_tuser;
    for (int i = 0; i < 4; i++) begin
      comp[i] = in_tdata[i*SAMP_W +: SAMP_W];
      q[i]    = {comp[i][SAMP_W-1], comp[i]};
      qabs[i] = q[i][16] ? -q[i] : q[i];
    end
    idx  = 2'd0;
    best = qabs[0];
    for (int i = 1; i < 4; i++) begin
      if (best < qabs[i]) begin
        best = qabs[i];
        idx  = 2'(i);
      end
    end
    if (q[idx][16]) begin
      for (int i = 0; i < 4; i++) q[i] = -q[i];
    end
    idx_in = (kind_in == KIND_DECOMPRESS) ? in_tdata[95:94] : idx;
  end

  // Ready chain: each stage moves when it is empty or its successor moves.
  assign rdy_out   = !out_valid_r || out_tready;
  assign rdy5      = !v5_r || isq_rdy;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Route the three kept components or codes to the lanes.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r <= kind_in;
      idx1_r  <= idx_in;
      for (int k = 0; k < LANES; k++) begin
        raw1_r[k]  <= (2'(k) < idx) ? q[k] : q[k+1];
        code1_r[k] <= in_tdata[64 + k*CODE_W +: CODE_W];
      end
    end
    if (rdy2) begin
      kind2_r <= kind1_r;
      idx2_r  <= idx1_r;
    end
    if (rdy3) begin
      kind3_r <= kind2_r;
      idx3_r  <= idx2_r;
    end
    if (rdy4) begin
      kind4_r <= kind3_r;
      idx4_r  <= idx3_r;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    stq_lane u_lane (
      .clk      (clk),
      .en2      (rdy2),
      .en3      (rdy3),
      .en4      (rdy4),
      .kind     (kind1_r),
      .raw      (raw1_r[k]),
      .code_in  (code1_r[k]),
      .code_out (lcode[k]),
      .val_out  (lval[k]),
      .sq_out   (lsq[k])
    );
  end

  // Merge the lanes: radicand of the dropped component and the side payload.
  always_comb begin
    sum = lsq[0] + lsq[1] + lsq[2];
    rad_nxt = (sum >= 32'h4000_0000) ? '0 : RAD_W'(32'h4000_0000 - sum);
    side_nxt.kind = kind4_r;
    side_nxt.idx  = idx4_r;
    for (int k = 0; k < LANES; k++) begin
      side_nxt.codes[k] = lcode[k];
      side_nxt.vals[k]  = lval[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      rad5_r  <= rad_nxt;
      side5_r <= side_nxt;
    end
  end

  stq_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_ready  (isq_rdy),
    .x         (rad5_r),
    .side_in   (side5_r),
    .out_valid (isq_valid),
    .out_ready (rdy_out),
    .root      (isq_root),
    .rem       (isq_rem),
    .side_out  (side_o)
  );

  // Round the root, saturate full scale and assemble the result.
  always_comb begin
    rnd = ({1'b0, isq_rem} > isq_root) ? isq_root + 1'b1 : isq_root;
    root_s = rnd[SAMP_W-1] ? samp_t'(16'sh7fff) : samp_t'(rnd[SAMP_W-1:0]);
    for (int i = 0; i < 4; i++) begin
      if (side_o.kind == KIND_COMPRESS) begin
        res[i] = '0;
      end else if (2'(i) == side_o.idx) begin
        res[i] = root_s;
      end else if (2'(i) < side_o.idx) begin
        res[i] = side_o.vals[i];
      end else begin
        res[i] = side_o.vals[(i > 0) ? i - 1 : 0];
      end
    end
    out_data_nxt = '0;
    if (side_o.kind == KIND_COMPRESS) begin
      out_data_nxt[31:0] = {side_o.idx, side_o.codes[2], side_o.codes[1], side_o.codes[0]};
    end
    for (int i = 0; i < 4; i++) out_data_nxt[32 + i*SAMP_W +: SAMP_W] = res[i];
    out_data_nxt[97:96] = side_o.idx;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= isq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= side_o.kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An empty output register means nothing can block the input.
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty output register");

  // A compress result carries its index in the packed word too.
  a_idx_packed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_COMPRESS |-> out_data_r[31:30] == out_data_r[97:96])
    else $error("packed index and largest index disagree");

  // The rebuilt component of a decompress result is never negative.
  a_root_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_DECOMPRESS && out_data_r[97:96] == 2'd0
      |-> !out_data_r[47])
    else $error("rebuilt component is negative");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the smallest-three quaternion codec
// Drives compress and decompress requests through the stream input and
// predicts every result with a local fixed-point model. Each result is checked
// field by field, in order, while both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stq_pkg::*;

  localparam int  LATENCY     = 22;
  localparam int  CYCLE_LIMIT = 300000;
  localparam longint QK       = 64'sd1518500250;

  typedef struct {
    logic [31:0] packed_out;
    logic [15:0] w, x, y, z;
    logic [1:0]  largest;
  } quat_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  quat_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int n_compress = 0;
  int n_decompress = 0;
  int n_checked = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  int hold_cycles = 0;

  smallest_three_quat_codec uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // Hard stop on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Quantize one component to a 10-bit code, clamped to +-1/sqrt2.
  function automatic longint quant_code(longint raw);
    longint lim;
    longint t;
    longint code;
    lim = 64'sd1 << 45;
    t = raw * QK;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    code = (((t + lim) << 9) + (64'sd1 << 44)) >>> 45;
    if (code > 1023) code = 1023;
    return code;
  endfunction

  // Turn a 10-bit code back into a Q1.15 value, halves away from zero.
  function automatic longint dequant_code(longint code);
    longint d;
    longint mag;
    longint r;
    d = 2 * code - 1024;
    mag = (d < 0 ? -d : d) * QK;
    r = (mag + (64'sd1 << 25)) >>> 26;
    return d < 0 ? -r : r;
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint root_nearest(longint v);
    longint r;
    r = 0;
    for (int b = 15; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  // Expected result of one request.
  function automatic quat_result_t codec_predict(logic kind, logic [95:0] data);
    quat_result_t res;
    longint q[4];
    longint best, a, sum, root;
    int idx, k;
    logic [31:0] word;
    res = '{default: '0};
    if (kind == KIND_COMPRESS) begin
      for (int i = 0; i < 4; i++) q[i] = longint'($signed(data[16*i +: 16]));
      idx = 0;
      best = q[0] < 0 ? -q[0] : q[0];
      for (int i = 1; i < 4; i++) begin
        a = q[i] < 0 ? -q[i] : q[i];
        if (best < a) begin
          best = a;
          idx = i;
        end
      end
      if (q[idx] < 0)
        for (int i = 0; i < 4; i++) q[i] = -q[i];
      word = '0;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        if (i != idx) begin
          word[10*k +: 10] = 10'(quant_code(q[i]));
          k++;
        end
      end
      word[31:30] = 2'(idx);
      res.packed_out = word;
      res.largest = 2'(idx);
    end else begin
      word = data[95:64];
      idx = int'(word[31:30]);
      sum = 0;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        if (i != idx) begin
          q[i] = dequant_code(longint'(word[10*k +: 10]));
          sum += q[i] * q[i];
          k++;
        end
      end
      root = sum >= (64'sd1 << 30) ? 0 : root_nearest((64'sd1 << 30) - sum);
      if (root > 32767) root = 32767;
      q[idx] = root;
      res.w = q[0][15:0];
      res.x = q[1][15:0];
      res.y = q[2][15:0];
      res.z = q[3][15:0];
      res.largest = 2'(idx);
    end
    return res;
  endfunction

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_request(logic kind, logic [15:0] w, logic [15:0] x,
                              logic [15:0] y, logic [15:0] z, logic [31:0] p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {p, z, y, x, w};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(codec_predict(kind, {p, z, y, x, w}));
    if (kind == KIND_COMPRESS) n_compress++;
    else n_decompress++;
  endtask

  task automatic send_compress(logic [15:0] w, logic [15:0] x,
                               logic [15:0] y, logic [15:0] z);
    send_request(KIND_COMPRESS, w, x, y, z, $urandom);
  endtask

  task automatic send_decompress(logic [31:0] p);
    send_request(KIND_DECOMPRESS, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), p);
  endtask

  // Near-unit quaternion: one component from a larger range, the rest from a smaller one.
  task automatic send_unit_quat(output logic [15:0] c[4]);
    int big;
    big = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      if (i == big) c[i] = 16'($urandom_range(16384, 32767));
      else c[i] = 16'($urandom_range(0, 23500));
      if ($urandom_range(0, 1)) c[i] = -c[i];
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, an optional long hold, and the compare.
  initial begin : result_checker
    int stall;
    quat_result_t exp_r;
    quat_result_t got;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        stall = hold_cycles;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.packed_out = out_tdata[31:0];
      got.w = out_tdata[47:32];
      got.x = out_tdata[63:48];
      got.y = out_tdata[79:64];
      got.z = out_tdata[95:80];
      got.largest = out_tdata[97:96];
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (got.packed_out !== exp_r.packed_out) begin
          $error("packed_out expected %h got %h", exp_r.packed_out, got.packed_out);
          errors++;
        end
        if (got.w !== exp_r.w) begin
          $error("out_w expected %h got %h", exp_r.w, got.w);
          errors++;
        end
        if (got.x !== exp_r.x) begin
          $error("out_x expected %h got %h", exp_r.x, got.x);
          errors++;
        end
        if (got.y !== exp_r.y) begin
          $error("out_y expected %h got %h", exp_r.y, got.y);
          errors++;
        end
        if (got.z !== exp_r.z) begin
          $error("out_z expected %h got %h", exp_r.z, got.z);
          errors++;
        end
        if (got.largest !== exp_r.largest) begin
          $error("largest_index expected %0d got %0d", exp_r.largest, got.largest);
          errors++;
        end
      end
    end
  end

  // Extremes, ties, negation of the most negative value, clamping,
  // code saturation, negative radicand and full-scale rebuild.
  task automatic test_directed();
    send_compress(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_compress(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_compress(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_compress(16'h0000, 16'h8000, 16'h7FFF, 16'h0001);
    send_compress(16'h0000, 16'h0000, 16'h8000, 16'h0000);
    send_compress(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_compress(16'h4000, 16'hC000, 16'h4000, 16'hC000);
    send_compress(16'hC000, 16'h4000, 16'h4000, 16'h4000);
    send_compress(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_compress(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_compress(16'h7FFF, 16'h8001, 16'h5A82, 16'hA57E);
    send_compress(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    send_decompress(32'h0000_0000);
    send_decompress(32'hFFFF_FFFF);
    send_decompress(32'h2008_0200);
    send_decompress(32'h6008_0200);
    send_decompress(32'hA008_0200);
    send_decompress(32'hE008_0200);
    send_decompress(32'h3FFF_FFFF);
    send_decompress(32'hC000_0000);
    send_decompress(32'h8000_0000 | (32'd724 << 20) | (32'd300 << 10) | 32'd512);
    send_decompress(32'h4000_0000 | (32'd512 << 20) | (32'd512 << 10) | 32'd1023);
  endtask

  // Mostly near-unit quaternions, some raw noise.
  task automatic test_random_compress(int count);
    logic [15:0] c[4];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_compress(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_unit_quat(c);
        send_compress(c[0], c[1], c[2], c[3]);
      end
    end
  endtask

  // Random words plus words with codes near the valid region.
  task automatic test_random_decompress(int count);
    logic [31:0] p;
    for (int n = 0; n < count; n++) begin
      p = $urandom;
      if ($urandom_range(0, 1))
        for (int k = 0; k < 3; k++) p[10*k +: 10] = 10'($urandom_range(150, 874));
      send_decompress(p);
    end
  endtask

  // A mix of both kinds with no idling on either side.
  task automatic test_back_to_back(int count);
    no_idle = 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1)) test_random_compress(1);
      else test_random_decompress(1);
    end
    no_idle = 0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall.
  task automatic test_output_hold();
    in_tvalid <= 1'b0;
    wait_drained();
    hold_cycles = 120;
    hold_req = 1;
    no_idle = 1;
    for (int n = 0; n < 60; n++) begin
      if (n % 2) test_random_compress(1);
      else test_random_decompress(1);
    end
    no_idle = 0;
  endtask

  // The sender stops until every outstanding request has completed.
  task automatic test_sender_pause();
    test_random_compress(10);
    in_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);
    test_random_decompress(10);
  endtask

  initial begin : main
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_compress(200);
    test_random_decompress(150);
    test_back_to_back(60);
    test_output_hold();
    test_sender_pause();
    test_random_compress(25);
    test_random_decompress(25);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d compress and %0d decompress requests, %0d results checked,",
             n_compress, n_decompress, n_checked);
    $display("with random stalls, a long output hold and a sender pause.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
